// File: rtl/core/nfa_pkg.sv
// shared types, codes and helpers of the next-fit id allocator
package nfa_pkg;

  // bitmap word geometry
  localparam int WORD_W = 32;
  localparam int OFF_W  = 5;

  // request kinds
  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_REALLOC = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  // one bitmap word handed to the word evaluator
  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic              row_valid;
    logic              first;
    logic              wrap;
    logic              last_word;
    logic [OFF_W-1:0]  off;
  } scan_in_t;

  // evaluator answer
  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] pos;
  } scan_out_t;

  // lowest set bit of a word
  function automatic logic [OFF_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [OFF_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = OFF_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/core/nfa_if.sv
// request and response channel interfaces of the id allocator
interface nfa_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] old_id;

  modport source (output valid, output func, output old_id, input ready);
  modport sink (input valid, input func, input old_id, output ready);
endinterface

interface nfa_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] id;
  logic       ok;

  modport source (output valid, output id, output ok, input ready);
  modport sink (input valid, input id, input ok, output ready);
endinterface

// File: rtl/core/next_fit_id_allocator_top.sv
// next-fit id allocator: bitmap in ram words, circular scan, one response per request
// allocate and reallocate scan from the search pointer; reallocate also frees its old id
//   when in range and not the grant; release frees one id; unused kinds and a full table fail
// throughput: one request at a time; the scan reads one 32-bit bitmap word per cycle
//   through the single ram read port, so a full scan of 256 ids takes 9 word reads
// reset: control, search pointer and per-word valid bits clear at once; no clearing pass
module next_fit_id_allocator_top #(
  parameter int NUM_IDS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  nfa_req_if.sink          req_i,
  nfa_rsp_if.source        rsp_o
);

  localparam int WORD_W    = nfa_pkg::WORD_W;
  localparam int OFF_W     = nfa_pkg::OFF_W;
  localparam int NW        = (NUM_IDS + WORD_W - 1) / WORD_W;
  localparam int AW        = (NW > 1) ? $clog2(NW) : 1;
  localparam int BW        = AW + OFF_W;
  localparam int XW        = ((BW > 8) ? BW : 8) + 1;
  localparam int CW        = $clog2(NW + 2);
  localparam int LAST_BITS = NUM_IDS - (NW - 1) * WORD_W;
  localparam logic [WORD_W-1:0] LAST_MASK = (LAST_BITS >= WORD_W) ? {WORD_W{1'b1}} :
                                            WORD_W'((64'd1 << LAST_BITS) - 64'd1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_WSET = 6'b000100,
    S_ROLD = 6'b001000,
    S_WOLD = 6'b010000,
    S_RESP = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [BW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     issue_cnt_q, issue_cnt_d;
  logic [AW-1:0]     raddr_q, raddr_d;
  logic              pend_q, pend_d;
  logic [CW-1:0]     pend_k_q;
  logic [AW-1:0]     pend_w_q;
  logic [NW-1:0]     row_vld_q;
  logic              rvld_q;
  logic              out_valid_q, out_valid_d;

  logic [1:0]        func_q;
  logic [7:0]        old_q;
  logic [AW-1:0]     slot_w_q, slot_w_d;
  logic [OFF_W-1:0]  slot_b_q, slot_b_d;
  logic [WORD_W-1:0] slot_row_q, slot_row_d;
  logic [7:0]        res_id_q, res_id_d;
  logic              res_ok_q, res_ok_d;
  logic [7:0]        out_id_q;
  logic              out_ok_q;

  logic              accept;
  logic              out_load;
  logic [XW-1:0]     in_x;
  logic              in_in_range;
  logic [XW-1:0]     old_x;
  logic              old_in_range;
  logic [BW-1:0]     old_g;
  logic [BW-1:0]     slot_g;
  logic [XW-1:0]     slot_x;
  logic              need_free;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] rdata_eff;

  nfa_pkg::scan_in_t  scan_in;
  nfa_pkg::scan_out_t scan_out;

  // handshakes
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_load    = (state_q == S_RESP) && (!out_valid_q || rsp_o.ready);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.id    = out_id_q;
  assign rsp_o.ok    = out_ok_q;

  // id range checks and index splits
  assign in_x         = XW'(req_i.old_id);
  assign in_in_range  = in_x < XW'(NUM_IDS);
  assign old_x        = XW'(old_q);
  assign old_in_range = old_x < XW'(NUM_IDS);
  assign old_g        = old_x[BW-1:0];
  assign slot_g       = {slot_w_q, slot_b_q};
  assign slot_x       = XW'(slot_g);
  assign need_free    = (func_q == nfa_pkg::FUNC_REALLOC) && old_in_range && (old_g != slot_g);
  assign rdata_eff    = rvld_q ? ram_rdata : '0;

  // ram port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = raddr_q;
    ram_we    = 1'b0;
    ram_waddr = slot_w_q;
    ram_wdata = slot_row_q | (WORD_W'(1) << slot_b_q);
    if (state_q == S_SCAN && issue_cnt_q < CW'(NW + 1)) begin
      ram_re = 1'b1;
    end
    if (state_q == S_ROLD) begin
      ram_re    = 1'b1;
      ram_raddr = old_g[BW-1:OFF_W];
    end
    if (state_q == S_WSET) begin
      ram_we = 1'b1;
    end
    if (state_q == S_WOLD) begin
      ram_we    = 1'b1;
      ram_waddr = old_g[BW-1:OFF_W];
      ram_wdata = rdata_eff & ~(WORD_W'(1) << old_g[OFF_W-1:0]);
    end
  end

  // bitmap storage
  nfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // word under evaluation
  assign scan_in.data      = ram_rdata;
  assign scan_in.row_valid = rvld_q;
  assign scan_in.first     = (pend_k_q == '0);
  assign scan_in.wrap      = (pend_k_q == CW'(NW));
  assign scan_in.last_word = (pend_w_q == AW'(NW - 1));
  assign scan_in.off       = ptr_q[OFF_W-1:0];

  nfa_word_eval #(
    .LIM_MASK (LAST_MASK)
  ) u_word_eval (
    .scan_i (scan_in),
    .scan_o (scan_out)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    issue_cnt_d = issue_cnt_q;
    raddr_d     = raddr_q;
    pend_d      = 1'b0;
    slot_w_d    = slot_w_q;
    slot_b_d    = slot_b_q;
    slot_row_d  = slot_row_q;
    res_id_d    = res_id_q;
    res_ok_d    = res_ok_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.func)
            nfa_pkg::FUNC_ALLOC, nfa_pkg::FUNC_REALLOC: begin
              issue_cnt_d = '0;
              raddr_d     = ptr_q[BW-1:OFF_W];
              state_d     = S_SCAN;
            end
            nfa_pkg::FUNC_RELEASE: begin
              res_id_d = req_i.old_id;
              res_ok_d = in_in_range;
              if (in_in_range) begin
                ptr_d   = in_x[BW-1:0];
                state_d = S_ROLD;
              end else begin
                state_d = S_RESP;
              end
            end
            default: begin
              res_id_d = '0;
              res_ok_d = 1'b0;
              state_d  = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        // issue one word read per cycle, wrapping over the rows
        if (ram_re) begin
          issue_cnt_d = issue_cnt_q + CW'(1);
          raddr_d     = (raddr_q == AW'(NW - 1)) ? '0 : raddr_q + AW'(1);
          pend_d      = 1'b1;
        end
        // evaluate the word returned by the previous read
        if (pend_q) begin
          if (scan_out.found) begin
            slot_w_d   = pend_w_q;
            slot_b_d   = scan_out.pos;
            slot_row_d = rdata_eff;
            pend_d     = 1'b0;
            state_d    = S_WSET;
          end else if (pend_k_q == CW'(NW)) begin
            res_id_d = '0;
            res_ok_d = 1'b0;
            pend_d   = 1'b0;
            state_d  = S_RESP;
          end
        end
      end
      S_WSET: begin
        ptr_d    = slot_g;
        res_id_d = slot_x[7:0];
        res_ok_d = 1'b1;
        state_d  = need_free ? S_ROLD : S_RESP;
      end
      S_ROLD: begin
        state_d = S_WOLD;
      end
      S_WOLD: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      issue_cnt_q <= '0;
      raddr_q     <= '0;
      pend_q      <= 1'b0;
      row_vld_q   <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      issue_cnt_q <= issue_cnt_d;
      raddr_q     <= raddr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (ram_re) begin
        rvld_q <= row_vld_q[ram_raddr];
      end
      if (ram_we) begin
        row_vld_q[ram_waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= req_i.func;
      old_q  <= req_i.old_id;
    end
    if (ram_re) begin
      pend_k_q <= issue_cnt_q;
      pend_w_q <= ram_raddr;
    end
    slot_w_q   <= slot_w_d;
    slot_b_q   <= slot_b_d;
    slot_row_q <= slot_row_d;
    res_id_q   <= res_id_d;
    res_ok_q   <= res_ok_d;
    if (out_load) begin
      out_id_q <= res_id_q;
      out_ok_q <= res_ok_q;
    end
  end

`ifndef SYNTHESIS
  // an accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  // a grant write sets the granted bit
  a_grant_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WSET) |-> (ram_we && ram_wdata[slot_b_q]))
    else $error("grant write does not mark the slot used");

  // an empty wrap visit ends the scan with a failure
  a_scan_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && pend_q && pend_k_q == CW'(NW) && !scan_out.found)
      |=> (state_q == S_RESP && !res_ok_q))
    else $error("full scan without a free slot did not fail");
`endif

endmodule

// File: rtl/core/nfa_ram.sv
// generic single-write single-read ram with registered read data
module nfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/core/nfa_word_eval.sv
// finds the first free slot of one bitmap word within the scan window
module nfa_word_eval #(
  parameter logic [31:0] LIM_MASK = 32'hFFFF_FFFF
) (
  input  nfa_pkg::scan_in_t  scan_i,
  output nfa_pkg::scan_out_t scan_o
);

  logic [nfa_pkg::WORD_W-1:0] used;
  logic [nfa_pkg::WORD_W-1:0] upper;
  logic [nfa_pkg::WORD_W-1:0] window;
  logic [nfa_pkg::WORD_W-1:0] lim;
  logic [nfa_pkg::WORD_W-1:0] free_bits;

  // a row never written reads as all free
  assign used  = scan_i.row_valid ? scan_i.data : '0;
  // bits at or above the pointer offset
  assign upper = {nfa_pkg::WORD_W{1'b1}} << scan_i.off;

  // window: first visit from the offset up, wrap visit below the offset, other visits the whole word
  always_comb begin
    if (scan_i.first) begin
      window = upper;
    end else if (scan_i.wrap) begin
      window = ~upper;
    end else begin
      window = '1;
    end
  end

  // slots past the id count in the last word stay out
  assign lim       = scan_i.last_word ? LIM_MASK : '1;
  assign free_bits = ~used & window & lim;

  assign scan_o.found = |free_bits;
  assign scan_o.pos   = nfa_pkg::lowest_set(free_bits);

endmodule
